[rtl/core/rlgr_pkg.sv]
// shared types and constants for the rlgr entropy encoder
// beat structs, adaptive state record and fixed-point state constants
// no dependencies
package rlgr_pkg;

    // state is fixed point with four fraction bits
    localparam int FracBits = 4;

    localparam logic [8:0] RUN_UP     = 9'd3;
    localparam logic [8:0] RUN_DOWN   = 9'd1;
    localparam logic [8:0] RICE_UP    = 9'd2;
    localparam logic [8:0] RICE_DOWN  = 9'd1;
    localparam logic [8:0] RUN_MAX    = 9'd256;
    localparam logic [8:0] RICE_MAX   = 9'd256;
    localparam logic [8:0] RUN_RESET  = 9'd0;
    localparam logic [8:0] RICE_RESET = 9'd32;

    typedef struct packed {
        logic signed [15:0] level;
        logic               last_in_block;
    } item_t;

    typedef struct packed {
        logic        lead_bit;
        logic [15:0] run_bits;
        logic [4:0]  run_len;
        logic        has_value;
        logic [14:0] quotient;
        logic [15:0] remainder;
        logic [4:0]  rem_len;
        logic        sign_bit;
        logic        block_end;
    } word_t;

    typedef struct packed {
        logic [8:0]  run_state;
        logic [8:0]  rice_state;
        logic [16:0] zero_run_count;
    } state_t;

    localparam state_t STATE_RESET = '{
        run_state:      RUN_RESET,
        rice_state:     RICE_RESET,
        zero_run_count: 17'd0
    };

endpackage

[rtl/core/rlgr_code.sv]
// code word former: one level against the current adaptive state
// gives the word, whether it is emitted, and the next state
// depends on rlgr_pkg
module rlgr_code
    import rlgr_pkg::*;
(
    input  state_t state,
    input  item_t  item,
    output word_t  word,
    output logic   emit,
    output state_t state_next
);

    logic [4:0]  k;
    logic [4:0]  order;
    logic        nonzero;
    logic        neg;
    logic [15:0] p16;
    logic [14:0] p;
    logic [14:0] q;
    logic [15:0] rem_mask;
    logic [9:0]  run_sum;
    logic [8:0]  run_inc;
    logic [8:0]  run_dec;
    logic [9:0]  rice_sum;
    logic [8:0]  rice_inc;
    logic [8:0]  rice_dec;
    logic [8:0]  rice_adapt;
    logic [16:0] zc_inc;
    logic [16:0] unit;

    assign k       = state.run_state[8:4];
    assign order   = state.rice_state[8:4];
    assign nonzero = (item.level != 16'sd0);
    assign neg     = item.level[15];

    // magnitude minus one: ~x for negatives, covers the most negative level
    assign p16      = neg ? ~item.level : (item.level - 16'sd1);
    assign p        = p16[14:0];
    assign q        = p >> order;
    assign rem_mask = ~(16'hFFFF << order);

    assign run_sum  = {1'b0, state.run_state} + {1'b0, RUN_UP};
    assign run_inc  = (run_sum > {1'b0, RUN_MAX}) ? RUN_MAX : run_sum[8:0];
    assign run_dec  = (state.run_state > RUN_DOWN) ? (state.run_state - RUN_DOWN) : 9'd0;

    assign rice_sum = {1'b0, state.rice_state} + {1'b0, RICE_UP};
    assign rice_inc = (rice_sum > {1'b0, RICE_MAX}) ? RICE_MAX : rice_sum[8:0];
    assign rice_dec = (state.rice_state > RICE_DOWN) ?
                      (state.rice_state - RICE_DOWN) : 9'd0;

    always_comb
    begin
        if (q != 15'd0)
            rice_adapt = rice_inc;
        else if (p == 15'd0)
            rice_adapt = rice_dec;
        else
            rice_adapt = state.rice_state;
    end

    assign zc_inc = state.zero_run_count + 17'd1;
    assign unit   = 17'd1 << k;

    always_comb
    begin
        word       = '0;
        emit       = 1'b0;
        state_next = state;

        if (k == 5'd0) begin
            emit = 1'b1;
            if (!nonzero) begin
                state_next.run_state = run_inc;
            end
            else begin
                word.lead_bit         = 1'b1;
                state_next.run_state  = run_dec;
                state_next.rice_state = rice_adapt;
            end
        end
        else if (!nonzero) begin
            state_next.zero_run_count = zc_inc;
            if (zc_inc >= unit) begin
                // full run unit
                emit                      = 1'b1;
                state_next.zero_run_count = 17'd0;
                state_next.run_state      = run_inc;
            end
            else if (item.last_in_block) begin
                // flush of a partial run
                emit                 = 1'b1;
                word.lead_bit        = 1'b1;
                word.run_bits        = zc_inc[15:0];
                word.run_len         = k;
                state_next.run_state = run_dec;
            end
        end
        else begin
            emit                      = 1'b1;
            word.lead_bit             = 1'b1;
            word.run_bits             = state.zero_run_count[15:0];
            word.run_len              = k;
            state_next.zero_run_count = 17'd0;
            state_next.run_state      = run_dec;
            state_next.rice_state     = rice_adapt;
        end

        if (word.lead_bit && nonzero) begin
            word.has_value = 1'b1;
            word.quotient  = q;
            word.remainder = p16 & rem_mask;
            word.rem_len   = order;
            word.sign_bit  = neg;
        end

        word.block_end = item.last_in_block;

        if (item.last_in_block)
            state_next = STATE_RESET;
    end

endmodule

[rtl/core/rlgr_entropy_encoder.sv]
// a level sits in the input register and is coded against the adaptive state register;
// its word goes to the result register; one level per cycle while no held word stalls it
// levels that only extend a run give no word and never wait on the output side
// reset (rst_n low, asynchronous): run state 0, rice state 32, zero count 0, no beats held
// top level of the rlgr entropy encoder, depends on rlgr_pkg and rlgr_code
module rlgr_entropy_encoder
    import rlgr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   word_valid,
    input  logic   word_stall,
    output word_t  word
);

    // input register: one level waiting to be coded
    logic   item_valid_reg;
    item_t  item_reg;

    // adaptive state: run mode, rice order, pending zeros
    state_t state_reg;
    state_t state_next;

    // result register: one code word beat
    logic   word_valid_reg;
    word_t  word_reg;

    word_t  code_word;
    logic   code_emit;
    logic   out_free;
    logic   advance;

    rlgr_code u_code (
        .state      (state_reg),
        .item       (item_reg),
        .word       (code_word),
        .emit       (code_emit),
        .state_next (state_next)
    );

    // the result register frees up in the same cycle its beat is taken
    assign out_free = !word_valid_reg || !word_stall;

    // a held level moves on when it makes no word or the word has room
    assign advance = item_valid_reg && (!code_emit || out_free);

    // new level only when the input register is empty or moving on
    assign item_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall) begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
    end

    // state steps once per coded level, including silent run extensions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end
        else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_valid_reg <= 1'b0;
        end
        else if (advance && code_emit) begin
            word_valid_reg <= 1'b1;
        end
        else if (!word_stall) begin
            word_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && code_emit)
            word_reg <= code_word;
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    // the last level of a block always yields a word
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && item_reg.last_in_block |-> code_emit)
    else $error("last level of block made no word");

    // state is back at reset after the last level moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.last_in_block |=>
            state_reg.run_state == RUN_RESET && state_reg.rice_state == RICE_RESET
            && state_reg.zero_run_count == 17'd0)
    else $error("state not cleared at block end");

    // pending zeros stay below one run unit, and none are pending outside run mode
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.zero_run_count < (17'd1 << state_reg.run_state[8:4])
        && (state_reg.run_state[8:4] != 5'd0 || state_reg.zero_run_count == 17'd0))
    else $error("zero run count out of range");

    // both adaptive states stay within saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.run_state <= RUN_MAX && state_reg.rice_state <= RICE_MAX)
    else $error("adaptive state past saturation");

    // a word waiting on a stall is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid_reg && word_stall |-> !(advance && code_emit))
    else $error("result overwritten while stalled");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for rlgr_entropy_encoder: directed table, then random level blocks
// carries its own run/rice state predictor; depends on rlgr_pkg and the encoder rtl only
module testbench;
    import rlgr_pkg::*;

    localparam int TotalLevels = 600;   // directed rows plus random levels
    localparam int CalmTail    = 80;    // last levels run with no idling on either side
    localparam int HoldCycles  = 60;    // long receiver hold-off that backs up the encoder
    localparam int HoldAfter   = 250;   // levels accepted before the hold-off starts
    localparam int QuietLimit  = 2000;  // cycles with no beat on either side before giving up
    localparam int DrainCycles = 10;    // tail wait after the last expected word

    // one row of the directed table: the level beat and, where it is obvious,
    // the code word typed in by hand
    typedef struct {
        item_t beat;
        bit    typed;
        word_t want;
    } vector_t;

    logic  clk;
    logic  rst_n;
    logic  item_valid;
    logic  item_stall;
    item_t item;
    logic  word_valid;
    logic  word_stall;
    word_t word;

    // predictor copy of the adaptive state
    logic [8:0]  run_st;
    logic [8:0]  rice_st;
    logic [16:0] zeros_pending;

    word_t expected_words[$];

    int  errors;
    int  levels_sent;
    int  words_checked;
    int  blocks_closed;
    int  max_run_order;
    int  max_rice_order;
    int  gap_odds;        // sender idles before a beat with odds 1 in gap_odds, 0 means never
    bit  calm;            // tail of the run, no idling anywhere
    bit  hold_active;     // receiver is in its long hold-off
    int  cycles;
    int  quiet;

    rlgr_entropy_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void clear_state();
        run_st        = RUN_RESET;
        rice_st       = RICE_RESET;
        zeros_pending = '0;
    endfunction

    // a zero in no-run mode or a full run unit pushes toward longer runs
    function automatic void run_up();
        run_st = (run_st + RUN_UP > RUN_MAX) ? RUN_MAX : run_st + RUN_UP;
    endfunction

    // a nonzero or a broken run pulls back, floor at zero
    function automatic void run_down();
        run_st = (run_st > RUN_DOWN) ? run_st - RUN_DOWN : '0;
    endfunction

    // golomb-rice fields of a nonzero level, then rice order adaptation
    function automatic void code_magnitude(input logic [15:0] lv, inout word_t w);
        logic [4:0]  order;
        logic        neg;
        logic [16:0] mag;
        logic [15:0] p;
        logic [15:0] q;
        order = 5'(rice_st >> FracBits);
        neg   = lv[15];
        // the most negative level has magnitude 32768, which needs all 16 bits as an unsigned value
        mag   = neg ? 17'h10000 - {1'b0, lv} : {1'b0, lv};
        p     = 16'(mag - 17'd1);
        q     = p >> order;
        w.has_value = 1'b1;
        w.quotient  = q[14:0];
        w.remainder = 16'(32'(p) & ((32'd1 << order) - 32'd1));
        w.rem_len   = order;
        w.sign_bit  = neg;
        if (int'(order) > max_rice_order)
            max_rice_order = int'(order);
        if (q != 16'd0)
            rice_st = (rice_st + RICE_UP > RICE_MAX) ? RICE_MAX : rice_st + RICE_UP;
        else if (p == 16'd0)
            rice_st = (rice_st > RICE_DOWN) ? rice_st - RICE_DOWN : '0;
    endfunction

    // advances the predicted state by one level; returns 1 when a code word comes out
    function automatic bit encode_level(input item_t beat, output word_t w);
        logic [4:0] k;
        bit         emits;
        w     = '0;
        emits = 1'b0;
        k     = 5'(run_st >> FracBits);
        if (int'(k) > max_run_order)
            max_run_order = int'(k);
        if (k == 5'd0) begin
            // no-run mode: every level is a word of its own
            if (beat.level == 16'sd0) begin
                run_up();
            end
            else begin
                w.lead_bit = 1'b1;
                code_magnitude(beat.level, w);
                run_down();
            end
            emits = 1'b1;
        end
        else if (beat.level == 16'sd0) begin
            zeros_pending = zeros_pending + 17'd1;
            if (32'(zeros_pending) >= (32'd1 << k)) begin
                // full unit of 2^k zeros
                zeros_pending = '0;
                run_up();
                emits = 1'b1;
            end
            else if (beat.last_in_block) begin
                // partial run flushed at block end, no value follows
                w.lead_bit = 1'b1;
                w.run_bits = zeros_pending[15:0];
                w.run_len  = k;
                run_down();
                emits = 1'b1;
            end
        end
        else begin
            // nonzero breaks the run: pending count, then the value
            w.lead_bit = 1'b1;
            w.run_bits = zeros_pending[15:0];
            w.run_len  = k;
            code_magnitude(beat.level, w);
            zeros_pending = '0;
            run_down();
            emits = 1'b1;
        end
        if (emits)
            w.block_end = beat.last_in_block;
        if (beat.last_in_block)
            clear_state();
        return emits;
    endfunction

    // ---------------------------------------------------------------
    // level side
    // ---------------------------------------------------------------

    function automatic vector_t row(input int lvl, input bit last, input bit typed,
                                    input word_t want);
        vector_t v;
        v.beat.level         = 16'(lvl);
        v.beat.last_in_block = last;
        v.typed              = typed;
        v.want               = want;
        return v;
    endfunction

    // offers one level beat, holds it until taken, then records the expected word
    task automatic offer(input item_t beat, input bit typed, input word_t want);
        word_t predicted;
        bit    emits;
        if (!calm && !hold_active && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        emits = encode_level(beat, predicted);
        // a hand-typed word replaces the prediction, the predictor still tracks state
        if (emits || typed)
            expected_words.push_back(typed ? want : predicted);
        if (beat.last_in_block)
            blocks_closed++;
        levels_sent++;
    endtask

    initial begin
        vector_t     plan[$];
        item_t       beat;
        int          blk_len;
        int          zero_pct;
        int          mag_kind;
        int          mag;
        bit          neg;
        bit          noise;
        logic [15:0] lvl;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        errors         = 0;
        levels_sent    = 0;
        words_checked  = 0;
        blocks_closed  = 0;
        max_run_order  = 0;
        max_rice_order = 0;
        gap_odds       = 4;
        calm           = 1'b0;
        hold_active    = 1'b0;
        clear_state();

        // directed table
        // fresh state, no-run mode: a zero is a bare lead-0 word
        plan.push_back(row(0, 0, 1, '0));
        // level 1 at order 2: lead 1, all value bits zero but the order
        plan.push_back(row(1, 0, 1, '{lead_bit: 1'b1, has_value: 1'b1, rem_len: 5'd2,
                                      default: '0}));
        // most negative level at order 1: magnitude 32768 codes as 32767
        plan.push_back(row(-32768, 0, 1, '{lead_bit: 1'b1, has_value: 1'b1,
                                           quotient: 15'd16383, remainder: 16'd1,
                                           rem_len: 5'd1, sign_bit: 1'b1, default: '0}));
        plan.push_back(row(32767, 0, 0, '0));
        // zero as last level in no-run mode
        plan.push_back(row(0, 1, 1, '{block_end: 1'b1, default: '0}));
        // six zeros lift the run order to 1
        repeat (6) plan.push_back(row(0, 0, 0, '0));
        plan.push_back(row(0, 0, 0, '0));       // pending zero, no word
        plan.push_back(row(0, 0, 0, '0));       // unit of two zeros complete
        plan.push_back(row(0, 0, 0, '0));       // pending zero
        plan.push_back(row(-5, 0, 0, '0));      // broken run with a value
        plan.push_back(row(0, 0, 0, '0));       // pending zero
        // unit completed on the last level: lead-0 word with block end, no flush
        plan.push_back(row(0, 1, 1, '{block_end: 1'b1, default: '0}));
        repeat (6) plan.push_back(row(0, 0, 0, '0));
        // partial run flushed at block end without a value
        plan.push_back(row(0, 1, 1, '{lead_bit: 1'b1, run_bits: 16'd1, run_len: 5'd1,
                                      block_end: 1'b1, default: '0}));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer(plan[i].beat, plan[i].typed, plan[i].want);

        // random part: mostly well-formed blocks with varied zero density and
        // magnitude range, some noise with stray block ends
        while (levels_sent < TotalLevels) begin
            blk_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 160)
                                                   : $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       zero_pct = 0;
                1:       zero_pct = 30;
                2:       zero_pct = 70;
                default: zero_pct = 95;
            endcase
            noise    = ($urandom_range(0, 7) == 0);
            mag_kind = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                default: gap_odds = 6;
            endcase
            for (int i = 0; i < blk_len && levels_sent < TotalLevels; i++) begin
                if (noise) begin
                    lvl = 16'($urandom());
                end
                else if ($urandom_range(0, 99) < zero_pct) begin
                    lvl = '0;
                end
                else begin
                    case (mag_kind)
                        0:       mag = $urandom_range(1, 4);
                        1:       mag = $urandom_range(1, 300);
                        2:       mag = $urandom_range(1, 32768);
                        default: mag = $urandom_range(0, 1) ? 32768 : 32767;
                    endcase
                    neg = $urandom_range(0, 1);
                    if (mag == 32768)
                        neg = 1'b1;
                    lvl = neg ? 16'(-mag) : 16'(mag);
                end
                beat.level         = lvl;
                beat.last_in_block = noise ? ($urandom_range(0, 3) == 0)
                                           : (i == blk_len - 1 || levels_sent == TotalLevels - 1);
                if (levels_sent >= TotalLevels - CalmTail)
                    calm = 1'b1;
                offer(beat, 1'b0, '0);
            end
        end
        item_valid <= 1'b0;

        // drain: the watchdog ends the run if a word never shows up
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("levels %0d in %0d closed blocks, %0d code words checked",
                 levels_sent, blocks_closed, words_checked);
        $display("highest run order reached %0d, highest rice order reached %0d",
                 max_run_order, max_rice_order);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // word side
    // ---------------------------------------------------------------

    // random stall bursts before the calm tail while the cycle counter modulo 400 is below
    // 300, one long hold-off once the run is under way so the encoder fills and stalls levels
    initial begin
        bit held;
        held = 1'b0;
        word_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!held && levels_sent >= HoldAfter) begin
                held        = 1'b1;
                hold_active = 1'b1;
                word_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                word_stall <= 1'b0;
                hold_active = 1'b0;
            end
            else if (!calm && (cycles % 400) < 300 && $urandom_range(0, 5) == 0) begin
                word_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                word_stall <= 1'b0;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // every accepted word beat is matched against the oldest expected word
    always @(posedge clk) begin
        word_t want;
        if (rst_n && word_valid && !word_stall) begin
            if (expected_words.size() == 0) begin
                $error("code word beat with nothing expected: %h", word);
                errors++;
            end
            else begin
                want = expected_words.pop_front();
                compare_field("lead_bit",  32'(want.lead_bit),  32'(word.lead_bit));
                compare_field("run_bits",  32'(want.run_bits),  32'(word.run_bits));
                compare_field("run_len",   32'(want.run_len),   32'(word.run_len));
                compare_field("has_value", 32'(want.has_value), 32'(word.has_value));
                compare_field("quotient",  32'(want.quotient),  32'(word.quotient));
                compare_field("remainder", 32'(want.remainder), 32'(word.remainder));
                compare_field("rem_len",   32'(want.rem_len),   32'(word.rem_len));
                compare_field("sign_bit",  32'(want.sign_bit),  32'(word.sign_bit));
                compare_field("block_end", 32'(want.block_end), 32'(word.block_end));
                words_checked++;
            end
        end
    end

    // watchdog: too many cycles without a beat on either side ends the run
    always @(posedge clk) begin
        if (rst_n) begin
            cycles++;
            if ((item_valid && !item_stall) || (word_valid && !word_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QuietLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        cycles = 0;
        quiet  = 0;
    end

endmodule
